[src/gradient_noise_3d_assert.svh]
// gradient_noise_3d_assert.svh: assertion macros shared by the checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef GRADIENT_NOISE_3D_ASSERT_SVH
`define GRADIENT_NOISE_3D_ASSERT_SVH

// same-cycle implication
`define GN3_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("gn3 check failed");

// next-cycle implication
`define GN3_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("gn3 check failed");

`endif

[src/gn3_pkg.sv]
// gn3_pkg: shared constants and types of the gradient noise block.
// No dependencies.
`default_nettype none
package gn3_pkg;
  localparam int TablesDef   = 4;
  localparam int FracBitsDef = 16;
  localparam int TableLen    = 512;
  localparam int IdxW        = 9;
  localparam int ByteW       = 8;
  localparam int CoordW      = 32;
  localparam int OutW        = 16;
  localparam int SelMaxW     = 4;
  localparam int ScaleQ16    = 61342;
  localparam int InDataW     = 120;
  localparam int InUserW     = 3;

  typedef enum logic {KindLoad = 1'b0, KindEval = 1'b1} kind_e;

  typedef struct packed {
    logic               load;
    logic [SelMaxW-1:0] sel;
    logic [IdxW-1:0]    idx;
    logic [ByteW-1:0]   val;
  } gn3_load_t;
endpackage
`default_nettype wire

[src/gradient_noise_3d.sv]
// gradient_noise_3d: top level of the 3D gradient noise pipeline.
// Depends on gn3_pkg, gn3_hash, gn3_fade, gn3_blend, gn3_ram.
//
// Input stream: tuser = {table_select, kind}; kind 0 loads one table byte,
// kind 1 evaluates noise at (coord_x, coord_y, coord_z), signed fixed point.
// Output stream: one transfer per evaluate, noise_value in signed Q2.14.
// Loads produce no output transfer.
// Throughput: one item per cycle while the output is not stalled; the
// table is replicated into 14 bank copies (2, 4 and 8 read ports for the
// three nested hash levels), each written by a load as it passes that
// level, so an evaluate sees every earlier load.
// Stall: the whole pipeline holds while the output register is full and
// not taken; s_axis_tready_o then drops. Nothing is lost or repeated.
// Reset: clears valid bits only; table contents are undefined until loaded.
`default_nettype none
module gradient_noise_3d import gn3_pkg::*; #(
  parameter int TABLES    = TablesDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // [8:0] entry_index, [16:9] entry_value, [48:17] coord_x,
  // [80:49] coord_y, [112:81] coord_z, rest zero
  input  wire logic [InDataW-1:0] s_axis_tdata_i,
  // [0] kind, [2:1] table_select
  input  wire logic [InUserW-1:0] s_axis_tuser_i,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // [15:0] noise_value
  output logic      [OutW-1:0]    m_axis_tdata_o
);
  localparam int W = FRAC_BITS;

  logic                  adv;
  kind_e                 kind;
  gn3_load_t             ld;
  logic [1:0]            tsel;
  logic signed [CoordW-1:0] c [3];
  logic [IdxW-1:0]       lo [3], hi [3];
  logic [W-1:0]          f [3], f1_q [3], f2_q [3], f3_q [3];
  logic [ByteW-1:0]      hash [8];
  logic signed [W+4:0]   fd [3];
  logic [7:1]            ev_q;
  logic                  mv_q;

  // table select modulo TABLES by repeated compare and subtract
  function automatic logic [SelMaxW-1:0] sel_wrap(input logic [1:0] s);
    logic [SelMaxW-1:0] r;
    r = SelMaxW'(s);
    for (int i = 0; i < 3; i++) begin
      if (32'(r) >= TABLES) begin
        r = r - SelMaxW'(TABLES);
      end
    end
    return r;
  endfunction

  assign adv  = !mv_q || m_axis_tready_i;
  assign kind = kind_e'(s_axis_tuser_i[0]);
  assign tsel = s_axis_tuser_i[2:1];

  assign ld.load = s_axis_tvalid_i && (kind == KindLoad);
  assign ld.sel  = sel_wrap(tsel);
  assign ld.idx  = s_axis_tdata_i[8:0];
  assign ld.val  = s_axis_tdata_i[16:9];

  assign c[0] = s_axis_tdata_i[48:17];
  assign c[1] = s_axis_tdata_i[80:49];
  assign c[2] = s_axis_tdata_i[112:81];

  for (genvar l = 0; l < 3; l++) begin : g_split
    logic [CoordW+IdxW-1:0] ce;
    assign ce    = {{IdxW{c[l][CoordW-1]}}, c[l]};
    assign lo[l] = ce[W+IdxW-1:W];
    assign hi[l] = lo[l] + IdxW'(1);
    assign f[l]  = c[l][W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= '0;
      mv_q <= 1'b0;
    end else if (adv) begin
      ev_q <= {ev_q[6:1], s_axis_tvalid_i && (kind == KindEval)};
      mv_q <= ev_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_q <= f;
      f2_q <= f1_q;
      f3_q <= f2_q;
    end
  end

  gn3_hash #(.TABLES(TABLES)) u_hash (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .ld_i  (ld),
    .lo_i  (lo),
    .hi_i  (hi),
    .hash_o(hash)
  );

  gn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade (
    .clk_i(clk_i),
    .adv_i(adv),
    .f_i  (f),
    .fd_o (fd)
  );

  gn3_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .hash_i (hash),
    .fr_i   (f3_q),
    .fd_i   (fd),
    .noise_o(m_axis_tdata_o)
  );

  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = mv_q;
endmodule
`default_nettype wire

[src/gn3_ram.sv]
// gn3_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module gn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

[src/gn3_hash.sv]
// gn3_hash: three-level corner hash over replicated permutation banks.
// Depends on gn3_pkg and gn3_ram. Loads write each bank group at its own stage.
`default_nettype none
module gn3_hash import gn3_pkg::*; #(
  parameter int TABLES = TablesDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire gn3_load_t       ld_i,
  input  wire logic [IdxW-1:0] lo_i [3],
  input  wire logic [IdxW-1:0] hi_i [3],
  output logic      [ByteW-1:0] hash_o [8]
);
  localparam int SelW  = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int Depth = TABLES * TableLen;
  localparam int AW    = $clog2(Depth);

  gn3_load_t       ld1_q, ld2_q;
  logic [IdxW-1:0] ixl1_q, ixh1_q, iyl1_q, iyh1_q, ixl2_q, ixh2_q;
  logic [ByteW-1:0] a_rd [2];
  logic [ByteW-1:0] b_rd [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld1_q <= '0;
      ld2_q <= '0;
    end else if (adv_i) begin
      ld1_q <= ld_i;
      ld2_q <= ld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ixl1_q <= lo_i[0];
      ixh1_q <= hi_i[0];
      iyl1_q <= lo_i[1];
      iyh1_q <= hi_i[1];
      ixl2_q <= ixl1_q;
      ixh2_q <= ixh1_q;
    end
  end

  for (genvar k = 0; k < 2; k++) begin : g_bank_a
    gn3_ram #(.WIDTH(ByteW), .DEPTH(Depth)) u_ram (
      .clk_i  (clk_i),
      .we_i   (adv_i && ld_i.load),
      .waddr_i(AW'({ld_i.sel[SelW-1:0], ld_i.idx})),
      .wdata_i(ld_i.val),
      .re_i   (adv_i),
      .raddr_i(AW'({ld_i.sel[SelW-1:0], (k == 1) ? hi_i[2] : lo_i[2]})),
      .rdata_o(a_rd[k])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank_b
    logic [IdxW-1:0] iy, idx;
    assign iy  = (k >= 2) ? iyh1_q : iyl1_q;
    assign idx = iy + IdxW'(a_rd[k % 2]);
    gn3_ram #(.WIDTH(ByteW), .DEPTH(Depth)) u_ram (
      .clk_i  (clk_i),
      .we_i   (adv_i && ld1_q.load),
      .waddr_i(AW'({ld1_q.sel[SelW-1:0], ld1_q.idx})),
      .wdata_i(ld1_q.val),
      .re_i   (adv_i),
      .raddr_i(AW'({ld1_q.sel[SelW-1:0], idx})),
      .rdata_o(b_rd[k])
    );
  end

  for (genvar k = 0; k < 8; k++) begin : g_bank_c
    logic [IdxW-1:0] ix, idx;
    assign ix  = (k >= 4) ? ixh2_q : ixl2_q;
    assign idx = ix + IdxW'(b_rd[k % 4]);
    gn3_ram #(.WIDTH(ByteW), .DEPTH(Depth)) u_ram (
      .clk_i  (clk_i),
      .we_i   (adv_i && ld2_q.load),
      .waddr_i(AW'({ld2_q.sel[SelW-1:0], ld2_q.idx})),
      .wdata_i(ld2_q.val),
      .re_i   (adv_i),
      .raddr_i(AW'({ld2_q.sel[SelW-1:0], idx})),
      .rdata_o(hash_o[k])
    );
  end
endmodule
`default_nettype wire

[src/gn3_fade.sv]
// gn3_fade: pipelined quintic fade 6t^5-15t^4+10t^3 for three lanes, 4 stages.
// Depends on gn3_pkg.
`default_nettype none
module gn3_fade import gn3_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         adv_i,
  input  wire logic        [FRAC_BITS-1:0]  f_i  [3],
  output logic signed      [FRAC_BITS+4:0]  fd_o [3]
);
  localparam int W  = FRAC_BITS;
  localparam int FW = W + 5;
  localparam logic [FW-1:0] Fifteen = FW'(15) << W;
  localparam logic [FW-1:0] Ten     = FW'(10) << W;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic        [W-1:0]      f1_q, f2f_q, sq_q, f3_q;
    logic signed [FW-1:0]     a1_q, p1_q, b_q;
    logic signed [W+FW:0]     fa, fb;
    logic        [2*W-1:0]    ff, f2f;

    assign fa  = $signed({1'b0, f1_q}) * a1_q;
    assign ff  = f1_q * f1_q;
    assign f2f = sq_q * f2f_q;
    assign fb  = $signed({1'b0, f3_q}) * b_q;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        f1_q  <= f_i[l];
        a1_q  <= $signed(FW'({f_i[l], 2'b0}) + FW'({f_i[l], 1'b0}) - Fifteen);
        p1_q  <= fa[W+FW-1:W];
        sq_q  <= ff[2*W-1:W];
        f2f_q <= f1_q;
        b_q   <= p1_q + $signed(Ten);
        f3_q  <= f2f[2*W-1:W];
        fd_o[l] <= fb[W+FW-1:W];
      end
    end
  end
endmodule
`default_nettype wire

[src/gn3_blend.sv]
// gn3_blend: corner gradients, z/y/x lerp stages, scale and saturation.
// Depends on gn3_pkg. Inputs aligned at stage 3 (hash, fraction) and 4 (fade).
`default_nettype none
module gn3_blend import gn3_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        adv_i,
  input  wire logic        [ByteW-1:0]     hash_i [8],
  input  wire logic        [FRAC_BITS-1:0] fr_i   [3],
  input  wire logic signed [FRAC_BITS+4:0] fd_i   [3],
  output logic             [OutW-1:0]      noise_o
);
  localparam int W  = FRAC_BITS;
  localparam int FW = W + 5;
  localparam int VW = W + 4;
  localparam int PW = VW + 18;
  localparam int SW = PW - W - 2;
  localparam logic signed [SW-1:0] OutMax = SW'(32767);
  localparam logic signed [SW-1:0] OutMin = -SW'(32768);

  function automatic logic signed [VW-1:0] grad(input logic [3:0] h,
      input logic signed [W:0] x, input logic signed [W:0] y, input logic signed [W:0] z);
    logic signed [VW-1:0] u, v;
    u = (h < 4'd8) ? VW'(x) : VW'(y);
    if (h < 4'd4) begin
      v = VW'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      v = VW'(x);
    end else begin
      v = VW'(z);
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [VW-1:0] lerp(input logic signed [FW-1:0] t,
      input logic signed [VW-1:0] a, input logic signed [VW-1:0] b);
    logic signed [VW:0]      diff;
    logic signed [FW+VW:0]   prod;
    logic signed [VW:0]      sum;
    diff = {b[VW-1], b} - {a[VW-1], a};
    prod = t * diff;
    sum  = {a[VW-1], a} + prod[W+VW:W];
    return sum[VW-1:0];
  endfunction

  logic signed [W:0]    g0 [3], g1 [3];
  logic signed [VW-1:0] g_q [8], z_q [4], y_q [2], n_q;
  logic signed [FW-1:0] fd1_q, fd0_q, fd0b_q;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] sc;

  for (genvar l = 0; l < 3; l++) begin : g_frac
    assign g0[l] = $signed({1'b0, fr_i[l]});
    assign g1[l] = $signed({1'b1, fr_i[l]});
  end

  assign prod = n_q * $signed(18'(ScaleQ16));
  assign sc   = prod[PW-1:W+2];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 8; k++) begin
        g_q[k] <= grad(hash_i[k][3:0], (k >= 4) ? g1[0] : g0[0],
                       (k % 4 >= 2) ? g1[1] : g0[1], (k % 2 == 1) ? g1[2] : g0[2]);
      end
      for (int k = 0; k < 4; k++) begin
        z_q[k] <= lerp(fd_i[2], g_q[2*k], g_q[2*k+1]);
      end
      fd1_q  <= fd_i[1];
      fd0_q  <= fd_i[0];
      for (int k = 0; k < 2; k++) begin
        y_q[k] <= lerp(fd1_q, z_q[2*k], z_q[2*k+1]);
      end
      fd0b_q <= fd0_q;
      n_q    <= lerp(fd0b_q, y_q[0], y_q[1]);
      if (sc > OutMax) begin
        noise_o <= OutW'(OutMax);
      end else if (sc < OutMin) begin
        noise_o <= OutW'(OutMin);
      end else begin
        noise_o <= sc[OutW-1:0];
      end
    end
  end
endmodule
`default_nettype wire

[src/gn3_checker.sv]
// gn3_checker: port-level checks of the noise block, bound to the top level.
// Depends on gn3_pkg and gradient_noise_3d_assert.svh.
`default_nettype none
`include "gradient_noise_3d_assert.svh"
module gn3_checker import gn3_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tvalid_i,
  input wire logic               s_axis_tready_o,
  input wire logic [InDataW-1:0] s_axis_tdata_i,
  input wire logic [InUserW-1:0] s_axis_tuser_i,
  input wire logic               m_axis_tvalid_o,
  input wire logic               m_axis_tready_i,
  input wire logic [OutW-1:0]    m_axis_tdata_o
);
  // stalled output transfer holds
  `GN3_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  // a stalled output blocks the input
  `GN3_ASSERT_NOW(a_stall_in, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o)
  // empty output never blocks input
  `GN3_ASSERT_NOW(a_idle_ready, !m_axis_tvalid_o, s_axis_tready_o)
endmodule

bind gradient_noise_3d gn3_checker u_gn3_checker (.*);
`default_nettype wire
